// ===== rtl/core/sorted_list_merge_macros.svh =====
// Assertion macros shared by the sorted list merge checker.
`ifndef SORTED_LIST_MERGE_MACROS_SVH
`define SORTED_LIST_MERGE_MACROS_SVH

// Same-cycle implication, sampled on clk_i, disabled during reset.
`define SLM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, disabled during reset.
`define SLM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/slm_pkg.sv =====
// Shared types and constants of the sorted list merge block.
package slm_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned CMD_W  = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FIRST  = 2'd0,
    CMD_PUSH_SECOND = 2'd1,
    CMD_MERGE       = 2'd2
  } cmd_e;

  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_MERGE = 1'b1
  } state_e;

  typedef logic [DATA_W-1:0] data_t;

endpackage

// ===== rtl/core/slm_list_ram.sv =====
// Single-port-write, registered-read memory holding one list.
module slm_list_ram #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = 5
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AW-1:0]       waddr_i,
  input  slm_pkg::data_t      wdata_i,
  input  logic [AW-1:0]       raddr_i,
  output slm_pkg::data_t      rdata_o
);

  slm_pkg::data_t mem_q [DEPTH];
  slm_pkg::data_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/sorted_list_merge.sv =====
// Usage: two ascending lists are loaded one value per input transaction; a
// merge command then streams out the merged ascending sequence.
// Input channel s_axis: tuser carries the command (push to first list, push
// to second list, merge), tdata the signed 32-bit value. A push to a full
// list is dropped. Pushes are accepted back to back.
// Output channel m_axis: tdata is the merged value, tlast marks the final
// value of the run. A merge on two empty lists produces nothing.
// After a merge command is accepted, the block enters the merge state and
// registers the first merged value (the heads already sit in the memories'
// read registers); after that one value per cycle while the receiver takes
// them, and the input is not ready until the final value is registered.
// Each list sits in a memory with a registered read; the read address
// follows the next head index, so the heads are ready on every cycle.
// When the receiver stalls, the output register holds its value and the
// merge pauses; pushes may be accepted while the final value still waits.
// Reset empties both lists and drops any merge in progress; list contents
// need no clearing since only loaded entries are read.
module sorted_list_merge #(
  parameter int unsigned FIRST_DEPTH  = 32,
  parameter int unsigned SECOND_DEPTH = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  logic [slm_pkg::DATA_W-1:0]  s_axis_tdata_i,   // [31:0] value
  input  logic [slm_pkg::CMD_W-1:0]   s_axis_tuser_i,   // [1:0] command
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  output logic [slm_pkg::DATA_W-1:0]  m_axis_tdata_o,   // [31:0] merged_value
  output logic                        m_axis_tlast_o
);

  localparam int unsigned ACW = $clog2(FIRST_DEPTH + 1);
  localparam int unsigned BCW = $clog2(SECOND_DEPTH + 1);
  localparam int unsigned AAW = (FIRST_DEPTH > 1) ? $clog2(FIRST_DEPTH) : 1;
  localparam int unsigned BAW = (SECOND_DEPTH > 1) ? $clog2(SECOND_DEPTH) : 1;

  slm_pkg::state_e state_q, state_d;
  logic [ACW-1:0]  ca_q, ca_d, i_q, i_d, i_n;
  logic [BCW-1:0]  cb_q, cb_d, j_q, j_d, j_n;
  logic            ov_q, ov_d;
  slm_pkg::data_t  odata_q, odata_d;
  logic            olast_q, olast_d;

  logic            in_acc;
  logic            fire;
  logic            a_avail, b_avail, take_first, is_last;
  logic            we_a, we_b;
  logic [AAW-1:0]  raddr_a;
  logic [BAW-1:0]  raddr_b;
  slm_pkg::data_t  head_a, head_b;

  slm_list_ram #(.DEPTH(FIRST_DEPTH), .AW(AAW)) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (ca_q[AAW-1:0]),
    .wdata_i (s_axis_tdata_i),
    .raddr_i (raddr_a),
    .rdata_o (head_a)
  );

  slm_list_ram #(.DEPTH(SECOND_DEPTH), .AW(BAW)) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (cb_q[BAW-1:0]),
    .wdata_i (s_axis_tdata_i),
    .raddr_i (raddr_b),
    .rdata_o (head_b)
  );

  assign in_acc = s_axis_tvalid_i && s_axis_tready_o;

  // FSM outputs
  always_comb begin
    s_axis_tready_o = (state_q == slm_pkg::ST_IDLE);
    fire            = (state_q == slm_pkg::ST_MERGE) && (!ov_q || m_axis_tready_i);
  end

  // FSM next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      slm_pkg::ST_IDLE: begin
        if (in_acc && (s_axis_tuser_i == slm_pkg::CMD_MERGE) &&
            ((ca_q != '0) || (cb_q != '0))) begin
          state_d = slm_pkg::ST_MERGE;
        end
      end
      slm_pkg::ST_MERGE: begin
        if (fire && is_last) begin
          state_d = slm_pkg::ST_IDLE;
        end
      end
      default: state_d = slm_pkg::ST_IDLE;
    endcase
  end

  // Head selection: equal heads take the second list first.
  always_comb begin
    a_avail    = (i_q < ca_q);
    b_avail    = (j_q < cb_q);
    take_first = a_avail && (!b_avail || ($signed(head_a) < $signed(head_b)));
    i_n        = i_q + ACW'(take_first);
    j_n        = j_q + BCW'(!take_first);
    is_last    = (i_n == ca_q) && (j_n == cb_q);
  end

  always_comb begin
    ca_d    = ca_q;
    cb_d    = cb_q;
    i_d     = i_q;
    j_d     = j_q;
    we_a    = 1'b0;
    we_b    = 1'b0;
    odata_d = odata_q;
    olast_d = olast_q;
    ov_d    = ov_q && !m_axis_tready_i;
    if (in_acc) begin
      case (s_axis_tuser_i)
        slm_pkg::CMD_PUSH_FIRST: begin
          if (ca_q < FIRST_DEPTH) begin
            we_a = 1'b1;
            ca_d = ca_q + ACW'(1);
          end
        end
        slm_pkg::CMD_PUSH_SECOND: begin
          if (cb_q < SECOND_DEPTH) begin
            we_b = 1'b1;
            cb_d = cb_q + BCW'(1);
          end
        end
        default: ;
      endcase
    end
    if (fire) begin
      ov_d    = 1'b1;
      odata_d = take_first ? head_a : head_b;
      olast_d = is_last;
      if (is_last) begin
        // run done: empty both lists, rewind heads
        ca_d = '0;
        cb_d = '0;
        i_d  = '0;
        j_d  = '0;
      end else begin
        i_d = i_n;
        j_d = j_n;
      end
    end
  end

  // Read the next head so it is registered by the following cycle.
  assign raddr_a = (i_d < FIRST_DEPTH) ? i_d[AAW-1:0] : '0;
  assign raddr_b = (j_d < SECOND_DEPTH) ? j_d[BAW-1:0] : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= slm_pkg::ST_IDLE;
      ca_q    <= '0;
      cb_q    <= '0;
      i_q     <= '0;
      j_q     <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ca_q    <= ca_d;
      cb_q    <= cb_d;
      i_q     <= i_d;
      j_q     <= j_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    odata_q <= odata_d;
    olast_q <= olast_d;
  end

  assign m_axis_tvalid_o = ov_q;
  assign m_axis_tdata_o  = odata_q;
  assign m_axis_tlast_o  = olast_q;

endmodule

// ===== rtl/core/slm_checker.sv =====
// Port-level assertions for the sorted list merge block, with its bind.
`include "sorted_list_merge_macros.svh"

module slm_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        s_axis_tvalid_i,
  input logic                        s_axis_tready_o,
  input logic [slm_pkg::CMD_W-1:0]   s_axis_tuser_i,
  input logic                        m_axis_tvalid_o,
  input logic                        m_axis_tready_i,
  input logic [slm_pkg::DATA_W-1:0]  m_axis_tdata_o,
  input logic                        m_axis_tlast_o
);

  logic push_acc;
  assign push_acc = s_axis_tvalid_i && s_axis_tready_o &&
                    (s_axis_tuser_i != slm_pkg::CMD_MERGE);

  `SLM_ASSERT_NXT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i,
                  m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o),
                  "stalled output changed")
  `SLM_ASSERT_IMP(a_busy_in_run, m_axis_tvalid_o && !m_axis_tlast_o, !s_axis_tready_o,
                  "input ready in the middle of a merge run")
  `SLM_ASSERT_NXT(a_run_no_gap, m_axis_tvalid_o && m_axis_tready_i && !m_axis_tlast_o,
                  m_axis_tvalid_o, "gap inside a merge run")
  `SLM_ASSERT_NXT(a_push_stays_ready, push_acc, s_axis_tready_o,
                  "push left the block busy")

endmodule

bind sorted_list_merge slm_checker u_slm_checker (.*);

// ===== tb/sorted_list_merge_tb.sv =====
// Testbench for sorted_list_merge: loads two lists, merges them and checks each merged value.
module sorted_list_merge_tb;

  localparam int unsigned FIRST_DEPTH  = 32;
  localparam int unsigned SECOND_DEPTH = 32;
  localparam logic [slm_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    slm_pkg::data_t value;
    logic           last;
  } merged_word_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       s_axis_tvalid = 1'b0;
  logic                       s_axis_tready;
  slm_pkg::data_t             s_axis_tdata = '0;   // [31:0] value
  logic [slm_pkg::CMD_W-1:0]  s_axis_tuser = '0;   // [1:0] command
  logic                       m_axis_tvalid;
  logic                       m_axis_tready = 1'b0;
  slm_pkg::data_t             m_axis_tdata;        // [31:0] merged_value
  logic                       m_axis_tlast;

  // Predictor state: list contents as the block should hold them.
  slm_pkg::data_t first_list_q[$];
  slm_pkg::data_t second_list_q[$];
  merged_word_t   merged_expected_q[$];
  merged_word_t   head_expected;

  int mismatches = 0;
  int effective_items = 0;
  int hold_request = 0;
  int hold_left = 0;
  bit calm = 1'b0;

  sorted_list_merge #(
    .FIRST_DEPTH  (FIRST_DEPTH),
    .SECOND_DEPTH (SECOND_DEPTH)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tlast_o  (m_axis_tlast)
  );

  always #1 clk_i = ~clk_i;

  initial begin
    #400000;
    $display("Mismatches found");
    $finish;
  end

  // Apply one accepted command to the list model; a merge queues its values.
  function automatic void record_command(logic [slm_pkg::CMD_W-1:0] cmd,
                                         slm_pkg::data_t val);
    bit             take_first;
    slm_pkg::data_t pick;
    case (cmd)
      slm_pkg::CMD_PUSH_FIRST: begin
        if (first_list_q.size() < FIRST_DEPTH) begin
          first_list_q.push_back(val);
          effective_items++;
        end
      end
      slm_pkg::CMD_PUSH_SECOND: begin
        if (second_list_q.size() < SECOND_DEPTH) begin
          second_list_q.push_back(val);
          effective_items++;
        end
      end
      slm_pkg::CMD_MERGE: begin
        effective_items++;
        while (first_list_q.size() + second_list_q.size() != 0) begin
          // equal heads: second list goes first
          take_first = (first_list_q.size() != 0) && (second_list_q.size() == 0 ||
                       $signed(first_list_q[0]) < $signed(second_list_q[0]));
          pick = take_first ? first_list_q.pop_front() : second_list_q.pop_front();
          merged_expected_q.push_back('{pick,
                                        first_list_q.size() + second_list_q.size() == 0});
        end
      end
      default: ;
    endcase
  endfunction

  task automatic send_item(input logic [slm_pkg::CMD_W-1:0] cmd, input slm_pkg::data_t val);
    while (!calm && $urandom_range(99) < 29) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= val;
    s_axis_tuser  <= cmd;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    record_command(cmd, val);
  endtask

  task automatic wait_drained;
    s_axis_tvalid <= 1'b0;
    while (merged_expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic slm_pkg::data_t pick_value(bit fresh, slm_pkg::data_t prev, bit tight);
    longint nxt;
    if (fresh) begin
      return tight ? slm_pkg::data_t'($urandom_range(16) - 8) : slm_pkg::data_t'($urandom);
    end
    nxt = longint'($signed(prev)) +
          (tight ? longint'($urandom_range(3)) : longint'($urandom_range(32'h0fff_ffff)));
    if (nxt > 64'sd2147483647) nxt = longint'($signed(prev));
    return slm_pkg::data_t'(nxt);
  endfunction

  function automatic int pick_size();
    int r;
    r = $urandom_range(99);
    if (r < 80) return $urandom_range(6);
    if (r < 95) return $urandom_range(20, 7);
    return $urandom_range(34, 28);
  endfunction

  // Push n_first and n_second values, interleaved at random between the lists.
  task automatic load_lists(input int n_first, input int n_second, input bit sorted,
                            input bit noisy);
    int             left_first;
    int             left_second;
    bit             tight;
    bit             pick_first;
    slm_pkg::data_t prev_first;
    slm_pkg::data_t prev_second;
    left_first  = n_first;
    left_second = n_second;
    tight       = $urandom_range(1);
    prev_first  = '0;
    prev_second = '0;
    while (left_first + left_second > 0) begin
      if (noisy && $urandom_range(99) < 4) send_item(CMD_UNUSED, $urandom);
      pick_first = (left_second == 0) || (left_first != 0 && $urandom_range(1) == 1);
      if (pick_first) begin
        prev_first = pick_value(!sorted || left_first == n_first, prev_first, tight);
        send_item(slm_pkg::CMD_PUSH_FIRST, prev_first);
        left_first--;
      end else begin
        prev_second = pick_value(!sorted || left_second == n_second, prev_second, tight);
        send_item(slm_pkg::CMD_PUSH_SECOND, prev_second);
        left_second--;
      end
    end
  endtask

  task automatic test_directed;
    send_item(slm_pkg::CMD_MERGE, 32'h0000_0000);
    send_item(CMD_UNUSED, 32'hffff_ffff);
    send_item(slm_pkg::CMD_MERGE, 32'hffff_ffff);
    send_item(slm_pkg::CMD_PUSH_FIRST, 32'h8000_0000);
    send_item(slm_pkg::CMD_PUSH_FIRST, 32'hffff_ffff);
    send_item(slm_pkg::CMD_PUSH_FIRST, 32'h0000_0000);
    send_item(slm_pkg::CMD_PUSH_FIRST, 32'h7fff_ffff);
    send_item(slm_pkg::CMD_PUSH_SECOND, 32'h8000_0000);
    send_item(slm_pkg::CMD_PUSH_SECOND, 32'h0000_0000);
    send_item(slm_pkg::CMD_PUSH_SECOND, 32'h0000_0000);
    send_item(slm_pkg::CMD_PUSH_SECOND, 32'h7fff_ffff);
    send_item(CMD_UNUSED, 32'h5555_5555);
    send_item(slm_pkg::CMD_MERGE, 32'haaaa_aaaa);
    // unsorted second list against a single first value
    send_item(slm_pkg::CMD_PUSH_SECOND, 32'd5);
    send_item(slm_pkg::CMD_PUSH_SECOND, -32'sd3);
    send_item(slm_pkg::CMD_PUSH_FIRST, 32'd1);
    send_item(slm_pkg::CMD_MERGE, 32'h0000_0000);
    send_item(slm_pkg::CMD_PUSH_FIRST, 32'd7);
    send_item(slm_pkg::CMD_MERGE, 32'h0000_0000);
    send_item(slm_pkg::CMD_MERGE, 32'h0000_0000);
  endtask

  // Overfill both lists and merge while the receiver holds off, then keep offering.
  task automatic test_full_lists_stalled;
    wait_drained();
    hold_request = 400;
    load_lists(FIRST_DEPTH + 2, SECOND_DEPTH + 2, 1'b1, 1'b0);
    send_item(slm_pkg::CMD_MERGE, $urandom);
    load_lists(3, 2, 1'b1, 1'b0);
    send_item(slm_pkg::CMD_MERGE, $urandom);
  endtask

  task automatic test_drain_pause;
    load_lists(4, 5, 1'b1, 1'b0);
    send_item(slm_pkg::CMD_MERGE, $urandom);
    wait_drained();
    load_lists(2, 0, 1'b1, 1'b0);
    send_item(slm_pkg::CMD_MERGE, $urandom);
  endtask

  task automatic test_random_merges;
    int goal;
    int round;
    goal  = effective_items + 330;
    round = 0;
    while (effective_items < goal) begin
      calm = (round >= 10 && round < 25);
      load_lists(pick_size(), pick_size(), $urandom_range(99) < 85, 1'b1);
      if ($urandom_range(99) < 93) send_item(slm_pkg::CMD_MERGE, $urandom);
      round++;
    end
    calm = 1'b0;
  endtask

  // Receiver: random stalls, plus a long hold-off on request.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (!calm && $urandom_range(99) < 29) begin
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (merged_expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected merged value %h last %b", m_axis_tdata, m_axis_tlast);
      end else begin
        head_expected = merged_expected_q.pop_front();
        if (m_axis_tdata !== head_expected.value || m_axis_tlast !== head_expected.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("merged value: expected %h last %b, got %h last %b",
                     head_expected.value, head_expected.last, m_axis_tdata, m_axis_tlast);
        end
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_full_lists_stalled();
    test_drain_pause();
    test_random_merges();
    s_axis_tvalid <= 1'b0;
    while (merged_expected_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
